// ===== hw/rtl/msac_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-sensor alarm controller package
// Shared codes, field widths and structs used by the alarm controller modules.
// ----------------------------------------------------------------------------
package msac_pkg;

   // Fixed field widths of the request and response channels.
   localparam int OP_WIDTH           = 2;
   localparam int SENSOR_INDEX_WIDTH = 4;
   localparam int SHOWN_WIDTH        = 4;

   // Request operation codes; the fourth code is unused and changes nothing.
   typedef logic [OP_WIDTH-1:0] op_type;
   localparam op_type OP_FIELD  = 2'd0;
   localparam op_type OP_DISARM = 2'd1;
   localparam op_type OP_EMPTY  = 2'd2;

   // Alarm mode of the controller.
   typedef enum logic [1:0] {
      MODE_DISENGAGED = 2'd0,
      MODE_ENGAGED    = 2'd1,
      MODE_DISARMED   = 2'd2
   } mode_type;

   // Control fields of one request transaction.
   typedef struct packed {
      op_type                        op;
      logic [SENSOR_INDEX_WIDTH-1:0] sensor_index;
      logic                          sensor_error;
      logic                          last_field;
   } ctrl_type;

   // One response transaction.
   typedef struct packed {
      mode_type               alarm_mode;
      logic                   alarm_pin;
      logic [SHOWN_WIDTH-1:0] shown_sensor;
      logic                   shown_changed;
   } result_type;

   // Configuration register indexes.
   localparam logic REG_ACTIVE_LEVEL = 1'b0;

endpackage

// ===== hw/rtl/multi_sensor_alarm_controller.sv =====
// ----------------------------------------------------------------------------
// Multi-sensor alarm controller
// Tracks an alarmed flag per remote sensor from ranged field readings and runs
// the disengaged / engaged / disarmed alarm mode with a configurable pin level.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Contents
//   req_*    in         one field reading, disarm request or fieldless update
//   rsp_*    out        mode, pin level, shown sensor, changed flag per request
//   csr_*    in/out     APB register port, register 0 = active_level
//
// Each request yields one response: it is held in the input register, then
// the core result lands in the output register. A new request is accepted
// every cycle; the input register and the output register decouple the sides,
// so a stalled response blocks intake only once both are full. Reset is
// synchronous: mode disengaged, all sensor flags clear, active_level 1.
// ----------------------------------------------------------------------------
module multi_sensor_alarm_controller import msac_pkg::*; #(
   parameter int MAX_SENSORS   = 16,
   parameter int READING_WIDTH = 32,
   localparam int REQ_TDATA_WIDTH =
      ((SENSOR_INDEX_WIDTH + 3 * READING_WIDTH + 7) / 8) * 8
) (
   input  logic                       clock,
   input  logic                       reset,

   // Request stream.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // sensor_index, reading, lower_limit, upper_limit, zero padding
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // op, sensor_error
   input  logic [2:0]                 req_tuser,
   input  logic                       req_tlast,

   // Response stream.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // alarm_mode, alarm_pin, shown_sensor, zero padding
   output logic [7:0]                 rsp_tdata,
   // shown_changed
   output logic                       rsp_tuser,

   // Configuration port.
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [2:0]                 csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   localparam int READING_LSB = SENSOR_INDEX_WIDTH;
   localparam int LOWER_LSB   = READING_LSB + READING_WIDTH;
   localparam int UPPER_LSB   = LOWER_LSB + READING_WIDTH;

   ctrl_type                        req_ctrl;
   ctrl_type                        ctrl_q;
   logic signed [READING_WIDTH-1:0] reading_q;
   logic signed [READING_WIDTH-1:0] lower_q;
   logic signed [READING_WIDTH-1:0] upper_q;
   logic                            in_valid;
   logic                            out_valid;
   logic                            advance;
   logic                            req_load;
   logic                            active_level;
   result_type                      core_result;
   result_type                      rsp_result;

   // Unpack the request fields.
   assign req_ctrl.op           = req_tuser[1:0];
   assign req_ctrl.sensor_error = req_tuser[2];
   assign req_ctrl.sensor_index = req_tdata[SENSOR_INDEX_WIDTH-1:0];
   assign req_ctrl.last_field   = req_tlast;

   // Core advances when it holds an item and the output register has room for its result.
   assign advance    = in_valid & (~out_valid | rsp_tready);
   assign req_tready = ~in_valid | advance;
   assign req_load   = req_tvalid & req_tready;

   msac_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .active_level (active_level)
   );

   msac_in_reg #(
      .READING_WIDTH (READING_WIDTH)
   ) u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .load          (req_load),
      .advance       (advance),
      .ctrl          (req_ctrl),
      .reading       (req_tdata[READING_LSB +: READING_WIDTH]),
      .lower_limit   (req_tdata[LOWER_LSB +: READING_WIDTH]),
      .upper_limit   (req_tdata[UPPER_LSB +: READING_WIDTH]),
      .valid         (in_valid),
      .ctrl_q        (ctrl_q),
      .reading_q     (reading_q),
      .lower_limit_q (lower_q),
      .upper_limit_q (upper_q)
   );

   msac_core #(
      .MAX_SENSORS   (MAX_SENSORS),
      .READING_WIDTH (READING_WIDTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .ctrl         (ctrl_q),
      .reading      (reading_q),
      .lower_limit  (lower_q),
      .upper_limit  (upper_q),
      .active_level (active_level),
      .result       (core_result)
   );

   msac_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .result_d (core_result),
      .ready    (rsp_tready),
      .valid    (out_valid),
      .result_q (rsp_result)
   );

   // Pack the response fields.
   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {1'b0, rsp_result.shown_sensor, rsp_result.alarm_pin,
                        rsp_result.alarm_mode};
   assign rsp_tuser  = rsp_result.shown_changed;

   // A switch into engaged is only ever reported with engaged mode.
   a_changed_engaged: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_result.shown_changed) |-> (rsp_result.alarm_mode == MODE_ENGAGED))
      else $error("shown_changed reported outside engaged mode");

   // The pin sounds exactly when the reported mode is engaged.
   a_pin_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_result.alarm_pin ==
                      ((rsp_result.alarm_mode == MODE_ENGAGED) ? active_level
                                                               : ~active_level)))
      else $error("alarm_pin does not match mode and active level");

   // A held request that the core did not take is not dropped.
   a_in_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid && !advance) |=> in_valid)
      else $error("pending request lost from the input register");

   // A result the core produced while output was stalled would overwrite it.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !rsp_tready) |-> !advance)
      else $error("core advanced into a stalled output register");

endmodule

// ===== hw/rtl/msac_csr.sv =====
// ----------------------------------------------------------------------------
// Alarm controller configuration registers
// APB-style register port holding the active level of the alarm pin.
// ----------------------------------------------------------------------------
module msac_csr import msac_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic        active_level
);

   logic active_level_ff;
   logic active_level_in;
   logic wr_en;

   // The port never inserts wait states.
   assign csr_pready = 1'b1;

   // A write completes in the access phase.
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      active_level_in = active_level_ff;
      if (wr_en && (csr_paddr[2] == REG_ACTIVE_LEVEL)) begin
         active_level_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_level_ff <= 1'b1;
      end else begin
         active_level_ff <= active_level_in;
      end
   end

   // Read data; only address bit 2 is decoded, so addresses 4 to 7 read as zero.
   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == REG_ACTIVE_LEVEL) begin
         csr_prdata = {31'd0, active_level_ff};
      end
   end

   assign active_level = active_level_ff;

endmodule

// ===== hw/rtl/msac_in_reg.sv =====
// ----------------------------------------------------------------------------
// Alarm controller input register
// Captures one request transaction and holds it until the core takes it.
// ----------------------------------------------------------------------------
module msac_in_reg import msac_pkg::*; #(
   parameter int READING_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic                            advance,
   input  ctrl_type                        ctrl,
   input  logic signed [READING_WIDTH-1:0] reading,
   input  logic signed [READING_WIDTH-1:0] lower_limit,
   input  logic signed [READING_WIDTH-1:0] upper_limit,
   output logic                            valid,
   output ctrl_type                        ctrl_q,
   output logic signed [READING_WIDTH-1:0] reading_q,
   output logic signed [READING_WIDTH-1:0] lower_limit_q,
   output logic signed [READING_WIDTH-1:0] upper_limit_q
);

   logic                            valid_ff;
   logic                            valid_in;
   ctrl_type                        ctrl_ff;
   logic signed [READING_WIDTH-1:0] reading_ff;
   logic signed [READING_WIDTH-1:0] lower_ff;
   logic signed [READING_WIDTH-1:0] upper_ff;

   // The slot empties when the core takes the item and refills on a load.
   assign valid_in = load | (valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         ctrl_ff    <= ctrl;
         reading_ff <= reading;
         lower_ff   <= lower_limit;
         upper_ff   <= upper_limit;
      end
   end

   assign valid         = valid_ff;
   assign ctrl_q        = ctrl_ff;
   assign reading_q     = reading_ff;
   assign lower_limit_q = lower_ff;
   assign upper_limit_q = upper_ff;

endmodule

// ===== hw/rtl/msac_core.sv =====
// ----------------------------------------------------------------------------
// Alarm controller core
// Range check, per-sensor alarmed flags, mode state machine and sensor
// selection, all evaluated in one pass for the item in the input register.
// ----------------------------------------------------------------------------
module msac_core import msac_pkg::*; #(
   parameter int MAX_SENSORS   = 16,
   parameter int READING_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  ctrl_type                        ctrl,
   input  logic signed [READING_WIDTH-1:0] reading,
   input  logic signed [READING_WIDTH-1:0] lower_limit,
   input  logic signed [READING_WIDTH-1:0] upper_limit,
   input  logic                            active_level,
   output result_type                      result
);

   mode_type               mode_ff;
   mode_type               mode_in;
   logic [MAX_SENSORS-1:0] flags_ff;
   logic [MAX_SENSORS-1:0] flags_in;
   logic                   update_hit_ff;
   logic                   update_hit_in;
   logic [SHOWN_WIDTH-1:0] selected_ff;
   logic [SHOWN_WIDTH-1:0] selected_in;

   logic                   field_hit;
   logic                   hit_acc;
   logic                   closing;
   logic                   close_hit;
   logic                   valid_close;
   logic                   any_alarmed;
   logic [SHOWN_WIDTH-1:0] first_alarmed;
   logic                   changed;

   // Strict out-of-range check of one field reading.
   assign field_hit = (reading < lower_limit) | (reading > upper_limit);
   assign hit_acc   = update_hit_ff | field_hit;

   // Decode how this item closes an update, if it does.
   always_comb begin
      closing       = 1'b0;
      close_hit     = 1'b0;
      update_hit_in = update_hit_ff;
      case (ctrl.op)
         OP_FIELD: begin
            closing       = ctrl.last_field;
            close_hit     = hit_acc;
            update_hit_in = ctrl.last_field ? 1'b0 : hit_acc;
         end
         OP_EMPTY: begin
            closing       = 1'b1;
            update_hit_in = 1'b0;
         end
         default: begin
            closing = 1'b0;
         end
      endcase
   end

   // Errored updates and unknown sensors leave the flags and mode alone.
   assign valid_close = closing & ~ctrl.sensor_error
                        & (32'(ctrl.sensor_index) < MAX_SENSORS);

   // New flag vector with the closed sensor's flag replaced.
   always_comb begin
      flags_in = flags_ff;
      for (int i = 0; i < MAX_SENSORS; i++) begin
         if (valid_close && (32'(ctrl.sensor_index) == i)) begin
            flags_in[i] = close_hit;
         end
      end
   end

   // Lowest-indexed alarmed sensor after the update, sensor 0 if none.
   assign any_alarmed = |flags_in;
   always_comb begin
      first_alarmed = '0;
      for (int i = MAX_SENSORS - 1; i >= 0; i--) begin
         if (flags_in[i]) begin
            first_alarmed = SHOWN_WIDTH'(i);
         end
      end
   end

   // Mode state machine: next state.
   always_comb begin
      mode_in = mode_ff;
      if (valid_close) begin
         case (mode_ff)
            MODE_DISARMED: begin
               if (close_hit) begin
                  mode_in = MODE_ENGAGED;
               end else if (!any_alarmed) begin
                  mode_in = MODE_DISENGAGED;
               end
            end
            default: begin
               mode_in = any_alarmed ? MODE_ENGAGED : MODE_DISENGAGED;
            end
         endcase
      end else if ((ctrl.op == OP_DISARM) && (mode_ff == MODE_ENGAGED)) begin
         mode_in = MODE_DISARMED;
      end
   end

   // Selection latches only on the transition into engaged.
   assign changed     = (mode_in == MODE_ENGAGED) & (mode_ff != MODE_ENGAGED);
   assign selected_in = !changed ? selected_ff
                        : (close_hit ? ctrl.sensor_index : first_alarmed);

   // Mode state machine: outputs for this transaction.
   always_comb begin
      result.alarm_mode    = mode_in;
      result.alarm_pin     = (mode_in == MODE_ENGAGED) ? active_level : ~active_level;
      result.shown_sensor  = selected_in;
      result.shown_changed = changed;
   end

   // State advances once per item taken from the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_DISENGAGED;
         flags_ff      <= '0;
         update_hit_ff <= 1'b0;
         selected_ff   <= '0;
      end else if (advance) begin
         mode_ff       <= mode_in;
         flags_ff      <= flags_in;
         update_hit_ff <= update_hit_in;
         selected_ff   <= selected_in;
      end
   end

endmodule

// ===== hw/rtl/msac_out_reg.sv =====
// ----------------------------------------------------------------------------
// Alarm controller output register
// Holds one response transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module msac_out_reg import msac_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result_d,
   input  logic       ready,
   output logic       valid,
   output result_type result_q
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   // Full while a result waits; a load may replace one being taken.
   assign valid_in = load | (valid_ff & ~ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_d;
      end
   end

   assign valid    = valid_ff;
   assign result_q = result_ff;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Multi-sensor alarm controller testbench
// Drives sensor updates, disarm requests and stray items into the request
// stream, predicts every response from a model of the alarm state and compares
// each response field by field. It changes the pin level register between
// phases and applies random idling, a long response stall and a drained pause.
// ----------------------------------------------------------------------------
module tb_top;
   import msac_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int REQ_TDATA_W      = ((SENSOR_INDEX_WIDTH + 3 * 32 + 7) / 8) * 8;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam logic [2:0] ACTIVE_LEVEL_ADDR = 3'(REG_ACTIVE_LEVEL) << 2;

   // One request transaction as the testbench keeps it.
   typedef struct packed {
      op_type                        op;
      logic [SENSOR_INDEX_WIDTH-1:0] sensor_index;
      logic                          sensor_error;
      logic [31:0]                   reading;
      logic [31:0]                   lower_limit;
      logic [31:0]                   upper_limit;
      logic                          last_field;
   } alarm_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // sensor_index, reading, lower_limit, upper_limit, zero padding
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // op, sensor_error
   logic [2:0]             req_tuser = '0;
   logic                   req_tlast = 1'b0;

   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // alarm_mode, alarm_pin, shown_sensor, zero padding
   logic [7:0]             rsp_tdata;
   // shown_changed
   logic                   rsp_tuser;

   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [2:0]             csr_paddr   = '0;
   logic [31:0]            csr_pwdata  = '0;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   // Stimulus and scoreboard storage.
   alarm_req_type pending_reqs[$];
   result_type    expected_rsps[$];
   int            mismatch_count = 0;

   // Test phase controls, written only by the sequencing process.
   bit quiet         = 1'b0;
   bit long_hold_req = 1'b0;

   // Predicted alarm state.
   mode_type                      pred_mode     = MODE_DISENGAGED;
   logic [15:0]                   alarmed_flags = '0;
   logic                          pending_hit   = 1'b0;
   logic [SHOWN_WIDTH-1:0]        chosen_sensor = '0;
   logic                          active_lvl    = 1'b1;

   multi_sensor_alarm_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   function automatic void report_mismatch(string what, longint want, longint got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch in %s: expected %0d, actual %0d", what, want, got);
      end
   endfunction

   // Closing an error-free update sets or clears its flag and updates the mode.
   function automatic void close_update(logic [SENSOR_INDEX_WIDTH-1:0] idx, logic err,
                                        logic hit);
      mode_type prev;
      int       lowest;
      prev        = pred_mode;
      lowest      = 0;
      pending_hit = 1'b0;
      if (err) begin
         return;
      end
      alarmed_flags[idx] = hit;
      if (pred_mode == MODE_DISARMED) begin
         if (hit) begin
            pred_mode = MODE_ENGAGED;
         end else if (alarmed_flags == '0) begin
            pred_mode = MODE_DISENGAGED;
         end
      end else begin
         pred_mode = (alarmed_flags != '0) ? MODE_ENGAGED : MODE_DISENGAGED;
      end
      if (prev != pred_mode && pred_mode == MODE_ENGAGED) begin
         for (int i = 15; i >= 0; i--) begin
            if (alarmed_flags[i]) lowest = i;
         end
         chosen_sensor = hit ? idx : SHOWN_WIDTH'(lowest);
      end
   endfunction

   // Advance the alarm state by one request and return the response it causes.
   function automatic result_type predict_alarm(alarm_req_type it);
      mode_type   prev;
      result_type res;
      prev = pred_mode;
      case (it.op)
         OP_FIELD: begin
            if ($signed(it.reading) < $signed(it.lower_limit) ||
                $signed(it.reading) > $signed(it.upper_limit)) begin
               pending_hit = 1'b1;
            end
            if (it.last_field) close_update(it.sensor_index, it.sensor_error, pending_hit);
         end
         OP_DISARM: begin
            if (pred_mode == MODE_ENGAGED) pred_mode = MODE_DISARMED;
         end
         OP_EMPTY: begin
            close_update(it.sensor_index, it.sensor_error, 1'b0);
         end
         default: begin
         end
      endcase
      res.alarm_mode    = pred_mode;
      res.alarm_pin     = (pred_mode == MODE_ENGAGED) ? active_lvl : ~active_lvl;
      res.shown_sensor  = chosen_sensor;
      res.shown_changed = (prev != pred_mode && pred_mode == MODE_ENGAGED);
      return res;
   endfunction

   // Request driver: presents the oldest pending item and predicts on acceptance.
   int gap_left = 0;
   always @(posedge clock) begin : req_driver
      logic          presenting;
      alarm_req_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= 0;
      end else begin
         presenting = req_tvalid;
         if (req_tvalid && req_tready) begin
            it = pending_reqs.pop_front();
            expected_rsps.push_back(predict_alarm(it));
            presenting = 1'b0;
         end
         if (!presenting) begin
            if (gap_left > 0) begin
               gap_left   <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0 && !quiet &&
                         $urandom_range(0, 7) == 0) begin
               gap_left   <= $urandom_range(0, 4);
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               it         = pending_reqs[0];
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_TDATA_W'({it.upper_limit, it.lower_limit, it.reading,
                                           it.sensor_index});
               req_tuser  <= {it.sensor_error, it.op};
               req_tlast  <= it.last_field;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response ready: random short stalls plus one long hold-off when requested.
   int  stall_left   = 0;
   int  hold_left    = 0;
   bit  hold_started = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold_req && !hold_started) begin
         hold_started <= 1'b1;
         hold_left    <= LONG_HOLD_CYCLES;
         rsp_tready   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Response monitor: each accepted transaction is checked against the oldest
   // expectation.
   always @(posedge clock) begin : rsp_monitor
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("response with nothing expected", 0, longint'(rsp_tdata));
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_tdata[1:0] !== want.alarm_mode)
               report_mismatch("alarm_mode", longint'(want.alarm_mode),
                               longint'(rsp_tdata[1:0]));
            if (rsp_tdata[2] !== want.alarm_pin)
               report_mismatch("alarm_pin", longint'(want.alarm_pin),
                               longint'(rsp_tdata[2]));
            if (rsp_tdata[6:3] !== want.shown_sensor)
               report_mismatch("shown_sensor", longint'(want.shown_sensor),
                               longint'(rsp_tdata[6:3]));
            if (rsp_tuser !== want.shown_changed)
               report_mismatch("shown_changed", longint'(want.shown_changed),
                               longint'(rsp_tuser));
         end
      end
   end

   task automatic push_req(op_type op, int idx, logic err, logic [31:0] rd,
                           logic [31:0] lo, logic [31:0] hi, logic last);
      alarm_req_type it;
      it.op           = op;
      it.sensor_index = SENSOR_INDEX_WIDTH'(idx);
      it.sensor_error = err;
      it.reading      = rd;
      it.lower_limit  = lo;
      it.upper_limit  = hi;
      it.last_field   = last;
      pending_reqs.push_back(it);
   endtask

   // One field reading whose limits either contain the reading or miss it.
   task automatic push_field(int idx, logic err, bit outside, logic last);
      int vals[$];
      for (int k = 0; k < 3; k++) begin
         if ($urandom_range(0, 2) == 0) vals.push_back($urandom_range(0, 8) - 4);
         else vals.push_back(int'($urandom));
      end
      vals.sort();
      if (!outside) push_req(OP_FIELD, idx, err, vals[1], vals[0], vals[2], last);
      else if ($urandom_range(0, 1) == 0) push_req(OP_FIELD, idx, err, vals[0], vals[1],
                                                   vals[2], last);
      else push_req(OP_FIELD, idx, err, vals[2], vals[0], vals[1], last);
   endtask

   // Mostly well-formed sensor updates, with disarms, fieldless updates and noise.
   task automatic queue_random_traffic(int count, int top_sensor);
      int  left;
      int  pick;
      int  fields;
      int  sensor;
      int  fire_at;
      bit  fire;
      logic err;
      left = count;
      while (left > 0) begin
         pick   = $urandom_range(0, 99);
         sensor = $urandom_range(0, top_sensor);
         err    = ($urandom_range(0, 9) == 0);
         if (pick < 68) begin
            fields  = $urandom_range(1, 4);
            fire    = ($urandom_range(0, 4) == 0);
            fire_at = $urandom_range(0, fields - 1);
            for (int f = 0; f < fields; f++) begin
               push_field(sensor, err, fire && f == fire_at, f == fields - 1);
            end
            left -= fields;
         end else begin
            if (pick < 82) begin
               push_req(OP_DISARM, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                        $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
            end else if (pick < 90) begin
               push_req(OP_EMPTY, sensor, err, $urandom, $urandom, $urandom,
                        1'($urandom_range(0, 1)));
            end else if (pick < 93) begin
               push_req(op_type'(3), $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                        $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
            end else begin
               push_req(OP_FIELD, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                        $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
            end
            left--;
         end
      end
   endtask

   // Waits until every item is accepted and every response has arrived.
   task automatic wait_for_drain();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes the pin level register, then reads it back.
   task automatic csr_write_check(logic level);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ACTIVE_LEVEL_ADDR;
      csr_pwdata  <= {31'b0, level};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      active_lvl = level;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== {31'b0, level}) report_mismatch("active_level readback",
                                                         longint'(level),
                                                         longint'(csr_prdata));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Test sequence.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: in-range extremes leave the sensor clear.
      push_req(OP_FIELD, 0, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
      // Reading above its upper limit engages on sensor 15.
      push_req(OP_FIELD, 15, 1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_fffe, 1'b1);
      push_req(OP_DISARM, 0, 1'b0, '0, '0, '0, 1'b0);
      // A second disarm while disarmed is ignored, as is the unused op code.
      push_req(OP_DISARM, 0, 1'b0, '0, '0, '0, 1'b0);
      push_req(op_type'(3), 9, 1'b1, 32'hffff_ffff, '0, '0, 1'b1);
      // Three-field update on sensor 3, the middle one below its lower limit.
      push_req(OP_FIELD, 3, 1'b0, 5, 5, 5, 1'b0);
      push_req(OP_FIELD, 3, 1'b0, 32'hffff_fffe, 32'hffff_ffff, 10, 1'b0);
      push_req(OP_FIELD, 3, 1'b0, 0, 0, 0, 1'b1);
      // Update in error changes nothing, both with fields and without.
      push_req(OP_FIELD, 3, 1'b1, 100, 0, 1, 1'b1);
      push_req(OP_EMPTY, 3, 1'b1, '0, '0, '0, 1'b0);
      // Fieldless updates clear sensors 15 and 3, back to disengaged.
      push_req(OP_EMPTY, 15, 1'b0, '0, '0, '0, 1'b0);
      push_req(OP_EMPTY, 3, 1'b0, '0, '0, '0, 1'b1);
      // A pending hit is dropped by a fieldless update of another sensor.
      push_req(OP_FIELD, 5, 1'b0, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
      push_req(OP_EMPTY, 7, 1'b0, '0, '0, '0, 1'b0);
      push_req(OP_FIELD, 5, 1'b0, 1, 0, 2, 1'b1);
      // A pending hit is dropped by an update closed in error.
      push_req(OP_FIELD, 6, 1'b0, 9, 0, 2, 1'b0);
      push_req(OP_FIELD, 6, 1'b1, 1, 0, 2, 1'b1);
      // Inverted limits always fire; a second sensor keeps it engaged.
      push_req(OP_FIELD, 2, 1'b0, 0, 1, 32'hffff_ffff, 1'b1);
      push_req(OP_FIELD, 9, 1'b0, 32'h7fff_ffff, 0, 0, 1'b1);
      push_req(OP_DISARM, 15, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
      // Clearing one sensor while disarmed keeps disarmed; clearing both disengages.
      push_req(OP_EMPTY, 2, 1'b0, '0, '0, '0, 1'b0);
      push_req(OP_FIELD, 9, 1'b0, 4, 4, 4, 1'b1);
      wait_for_drain();

      csr_write_check(1'b0);
      queue_random_traffic(270, 3);
      wait_for_drain();

      // Long response hold-off while requests keep coming.
      long_hold_req = 1'b1;
      queue_random_traffic(60, 15);
      wait_for_drain();

      csr_write_check(1'b1);
      queue_random_traffic(270, 15);
      wait_for_drain();

      csr_write_check(1'b0);
      quiet = 1'b1;
      queue_random_traffic(220, 5);
      wait_for_drain();

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
